// File: src/pbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse beat detector package
// Shared widths, register indexes, payload types and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package pbd_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 8;
    localparam int LEVEL_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int PEAK_BITS   = LEVEL_BITS - 1;
    localparam int TIME_BITS   = 32;
    localparam int ALPHA_BITS  = 8;
    localparam int GAIN_BITS   = 16;
    localparam int COUNT_BITS  = 8;
    localparam int BPM_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Shared multiplier operand widths and filter accumulator width.
    localparam int MUL_A_BITS = LEVEL_BITS;
    localparam int MUL_B_BITS = GAIN_BITS;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = LEVEL_BITS + ALPHA_BITS + 1;

    // Reset values.
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(500 << FRAC_BITS);
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET  = 8'd192;
    localparam logic [GAIN_BITS-1:0]  DECAY_RESET  = 16'd63570;
    localparam logic [15:0]           GAP_RESET    = 16'd300;
    localparam logic [15:0]           WINDOW_RESET = 16'd15000;
    localparam logic [7:0]            SCALE_RESET  = 8'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_ALPHA = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_DECAY   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_GAP      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BPM_SCALE    = 3'd4;

    // Operand selections for the shared multiplier.
    localparam logic [1:0] MUL_PREV   = 2'd0;
    localparam logic [1:0] MUL_SAMPLE = 2'd1;
    localparam logic [1:0] MUL_PEAK   = 2'd2;
    localparam logic [1:0] MUL_BPM    = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   time_ms;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] filtered_level;
        logic                  beat;
        logic                  bpm_valid;
        logic [BPM_BITS-1:0]   bpm;
        logic [COUNT_BITS-1:0] beats_so_far;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic [1:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       beat_step;
        logic       decay_step;
        logic       close_step;
    } t_cmd;

endpackage

// File: src/pbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse beat detector controller
// Sequences one sample through the filter, beat, decay and window steps
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module pbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pbd_pkg::t_cmd o_cmd
);
    import pbd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_A = 3'd1;
    localparam logic [2:0] S_MUL_B = 3'd2;
    localparam logic [2:0] S_BEAT  = 3'd3;
    localparam logic [2:0] S_DECAY = 3'd4;
    localparam logic [2:0] S_CLOSE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_sel  = MUL_PREV;
                o_cmd.acc_load = 1'b1;
                n_state        = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_sel = MUL_SAMPLE;
                o_cmd.acc_add = 1'b1;
                n_state       = S_BEAT;
            end
            S_BEAT: begin
                o_cmd.beat_step = 1'b1;
                n_state         = S_DECAY;
            end
            S_DECAY: begin
                o_cmd.mul_sel    = MUL_PEAK;
                o_cmd.decay_step = 1'b1;
                n_state          = S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.mul_sel = MUL_BPM;
                // Wait here until the output register can take the result.
                if (w_out_free) begin
                    o_cmd.close_step = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag: set when a result is written, cleared when taken.
    always_comb begin
        if (o_cmd.close_step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/pbd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse beat detector datapath
// Holds the configuration, the detector state and one shared multiplier
// that serves the filter, the peak decay and the BPM product in turn.
// ----------------------------------------------------------------------------
module pbd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pbd_pkg::t_cmd                       i_cmd,
    input  pbd_pkg::t_in_item                   i_in,
    input  logic                                i_cfg_valid,
    input  logic [pbd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output pbd_pkg::t_out_item                  o_out
);
    import pbd_pkg::*;

    // Configuration registers.
    logic [ALPHA_BITS-1:0] r_alpha;
    logic [GAIN_BITS-1:0]  r_decay;
    logic [15:0]           r_gap;
    logic [15:0]           r_window;
    logic [7:0]            r_scale;

    // Detector state.
    logic                   r_started;
    logic [LEVEL_BITS-1:0]  r_prev_level;
    logic [PEAK_BITS-1:0]   r_peak;
    logic [TIME_BITS-1:0]   r_last_beat;
    logic [TIME_BITS-1:0]   r_win_start;
    logic [COUNT_BITS-1:0]  r_beat_count;
    logic [BPM_BITS-1:0]    r_last_bpm;

    // Per-sample working registers.
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TIME_BITS-1:0]   r_time;
    logic [ACC_BITS-1:0]    r_acc;
    logic [LEVEL_BITS-1:0]  r_filtered;
    logic                   r_beat;
    t_out_item              r_out;

    logic [MUL_A_BITS-1:0]  w_mul_a;
    logic [MUL_B_BITS-1:0]  w_mul_b;
    logic [MUL_P_BITS-1:0]  w_prod;
    logic [ACC_BITS-1:0]    w_round;
    logic [LEVEL_BITS-1:0]  w_filtered;
    logic                   w_rising;
    logic [LEVEL_BITS-1:0]  w_delta;
    logic [TIME_BITS-1:0]   w_gap_elapsed;
    logic [TIME_BITS-1:0]   w_win_elapsed;
    logic                   w_beat;
    logic                   w_closed;
    logic [PEAK_BITS-1:0]   w_peak_new;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_PREV: begin
                w_mul_a = r_prev_level;
                w_mul_b = MUL_B_BITS'(r_alpha);
            end
            MUL_SAMPLE: begin
                w_mul_a = {r_sample, {FRAC_BITS{1'b0}}};
                w_mul_b = MUL_B_BITS'(9'd256 - {1'b0, r_alpha});
            end
            MUL_PEAK: begin
                w_mul_a = MUL_A_BITS'(r_peak);
                w_mul_b = r_decay;
            end
            MUL_BPM: begin
                w_mul_a = MUL_A_BITS'(r_beat_count);
                w_mul_b = MUL_B_BITS'(r_scale);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = MUL_P_BITS'(w_mul_a) * MUL_P_BITS'(w_mul_b);

    // Filter rounding, rise and beat test.
    assign w_round       = r_acc + ACC_BITS'(128);
    assign w_filtered    = w_round[LEVEL_BITS+7:8];
    assign w_rising      = (w_filtered >= r_prev_level);
    assign w_delta       = w_rising ? (w_filtered - r_prev_level) : '0;
    assign w_gap_elapsed = r_time - r_last_beat;
    assign w_beat        = w_rising && (w_delta >= LEVEL_BITS'(r_peak)) &&
                           (w_gap_elapsed > TIME_BITS'(r_gap));
    // A change too large for the peak register saturates.
    assign w_peak_new    = w_delta[LEVEL_BITS-1] ? '1 : w_delta[PEAK_BITS-1:0];

    // Window test.
    assign w_win_elapsed = r_time - r_win_start;
    assign w_closed      = (w_win_elapsed >= TIME_BITS'(r_window));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= ALPHA_RESET;
            r_decay  <= DECAY_RESET;
            r_gap    <= GAP_RESET;
            r_window <= WINDOW_RESET;
            r_scale  <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FILTER_ALPHA: r_alpha  <= i_cfg_data[ALPHA_BITS-1:0];
                CFG_PEAK_DECAY:   r_decay  <= i_cfg_data;
                CFG_MIN_GAP:      r_gap    <= i_cfg_data;
                CFG_WINDOW:       r_window <= i_cfg_data;
                CFG_BPM_SCALE:    r_scale  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Detector state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_prev_level <= LEVEL_RESET;
            r_peak       <= '0;
            r_last_beat  <= '0;
            r_win_start  <= '0;
            r_beat_count <= '0;
            r_last_bpm   <= '0;
        end else begin
            // The first sample starts both timers.
            if (i_cmd.load && !r_started) begin
                r_started   <= 1'b1;
                r_last_beat <= i_in.time_ms;
                r_win_start <= i_in.time_ms;
            end
            if (i_cmd.beat_step) begin
                r_prev_level <= w_filtered;
                if (w_beat) begin
                    r_peak      <= w_peak_new;
                    r_last_beat <= r_time;
                    if (r_beat_count != '1) begin
                        r_beat_count <= r_beat_count + 1'b1;
                    end
                end
            end
            if (i_cmd.decay_step) begin
                r_peak <= w_prod[PEAK_BITS+15:16];
            end
            if (i_cmd.close_step && w_closed) begin
                r_last_bpm   <= w_prod[BPM_BITS-1:0];
                r_beat_count <= '0;
                r_win_start  <= r_time;
            end
        end
    end

    // Working registers and the output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_in.sample;
            r_time   <= i_in.time_ms;
        end
        if (i_cmd.acc_load) begin
            r_acc <= w_prod[ACC_BITS-1:0];
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_prod[ACC_BITS-1:0];
        end
        if (i_cmd.beat_step) begin
            r_filtered <= w_filtered;
            r_beat     <= w_beat;
        end
        if (i_cmd.close_step) begin
            r_out.filtered_level <= r_filtered;
            r_out.beat           <= r_beat;
            r_out.bpm_valid      <= w_closed;
            r_out.bpm            <= w_closed ? w_prod[BPM_BITS-1:0] : r_last_bpm;
            r_out.beats_so_far   <= w_closed ? '0 : r_beat_count;
        end
    end

    assign o_out = r_out;

endmodule

// File: src/pulse_beat_detector_bpm.sv
`timescale 1ns / 1ps
// A sample is taken only in the idle state and stepped through the filter,
// beat, peak decay and close steps; the single shared multiplier serves the
// filter, peak decay and BPM products. A waiting output result does not stop
// the next sample being accepted; that sample waits in the close step until
// the result is taken. Reset (synchronous, active low) restores register
// defaults and detector state; the configuration port is always ready.
// ----------------------------------------------------------------------------
// Pulse beat detector with BPM window
// Filters pulse sensor samples, detects beats against a decaying peak and
// reports beats per minute at the end of each counting window.
// ----------------------------------------------------------------------------
module pulse_beat_detector_bpm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pbd_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pbd_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pbd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import pbd_pkg::*;

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    pbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and state.
    pbd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule
